[sv/sfe_pkg.sv]
`default_nettype none
package sfe_pkg;

	localparam int MAX_DELAY = 65536;
	localparam int PTR_W     = $clog2(MAX_DELAY);
	localparam int LEN_W     = PTR_W + 1;
	localparam int SAMPLE_W  = 16;
	localparam int CFG_W     = 17;
	localparam int ACC_W     = 34;
	localparam int COEF_W    = 18;
	localparam int PROD_W    = ACC_W + COEF_W;
	localparam int FRAC_SH   = 31;
	localparam int MOD_STEPS = LEN_W;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

	typedef enum logic [1:0] {
		CFG_ECHO_LEVEL   = 2'd0,
		CFG_NORM_GAIN    = 2'd1,
		CFG_DELAY_LENGTH = 2'd2,
		CFG_ECHO_ENABLE  = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LVL,
		ST_SUM,
		ST_GAIN,
		ST_SAT,
		ST_WRITE,
		ST_WMOD,
		ST_RMOD
	} st_t;

	// Status that the datapath hands to the sequencer.
	typedef struct packed {
		logic in_valid;
		logic echo_en;
		logic out_free;
		logic need_w;
		logic need_r;
		logic mod_done;
	} sts_t;

	// Controls that the sequencer hands to the datapath.
	typedef struct packed {
		logic in_ready;
		logic accept;
		logic mul_lvl;
		logic mul_gain;
		logic sum;
		logic sat;
		logic ch;
		logic commit;
		logic bypass;
		logic mod_start;
		logic mod_sel_r;
		logic wdone;
		logic rdone;
	} ctl_t;

endpackage
`default_nettype wire

[sv/sfe_mul.sv]
`default_nettype none
module sfe_mul (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [sfe_pkg::ACC_W-1:0]  a,
	input  wire logic signed [sfe_pkg::COEF_W-1:0] b,
	output logic signed [sfe_pkg::PROD_W-1:0]      prod
);
	import sfe_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(a) * PROD_W'(b);
		end
	end

	assign prod = prod_q;
endmodule
`default_nettype wire

[sv/sfe_mod.sv]
`default_nettype none
module sfe_mod (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [sfe_pkg::LEN_W-1:0]  dividend,
	input  wire logic [sfe_pkg::LEN_W-1:0]  divisor,
	output logic                            done,
	output logic [sfe_pkg::PTR_W-1:0]       rem
);
	import sfe_pkg::*;

	logic                 busy_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [LEN_W-1:0]     num_q;
	logic [LEN_W-1:0]     div_q;
	logic [LEN_W-1:0]     rem_q;
	logic [LEN_W-1:0]     trial;

	// The partial remainder stays below the divisor, so it fits in PTR_W bits.
	assign trial = {rem_q[PTR_W-1:0], num_q[LEN_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= MOD_CNT_W'(MOD_STEPS);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			num_q <= {num_q[LEN_W-2:0], 1'b0};
			rem_q <= (trial >= div_q) ? trial - div_q : trial;
		end
	end

	assign done = busy_q && (cnt_q == '0);
	assign rem  = rem_q[PTR_W-1:0];
endmodule
`default_nettype wire

[sv/sfe_ring.sv]
`default_nettype none
module sfe_ring (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      rd_en,
	input  wire logic [sfe_pkg::PTR_W-1:0] rd_addr,
	input  wire logic                      we,
	input  wire logic [sfe_pkg::PTR_W-1:0] wr_addr,
	input  wire logic [2*sfe_pkg::SAMPLE_W-1:0] wr_data,
	output logic [2*sfe_pkg::SAMPLE_W-1:0] rd_data
);
	import sfe_pkg::*;

	logic [2*SAMPLE_W-1:0] mem_q [MAX_DELAY];
	logic [2*SAMPLE_W-1:0] rd_data_q;
	logic                  rd_hit_q;
	logic [LEN_W-1:0]      fill_q;

	// Writes walk up from zero and only ever jump back to an entry already written, so the
	// written entries always form a prefix; anything at or above fill_q reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (we && ({1'b0, wr_addr} == fill_q)) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
			rd_hit_q  <= ({1'b0, rd_addr} < fill_q);
		end
	end

	assign rd_data = rd_hit_q ? rd_data_q : '0;
endmodule
`default_nettype wire

[sv/sfe_ctrl.sv]
`default_nettype none
module sfe_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sfe_pkg::sts_t sts,
	output sfe_pkg::ctl_t      ctl
);
	import sfe_pkg::*;

	st_t  state_q;
	st_t  state_nxt;
	logic ch_q;
	logic bypass_q;
	logic need_r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ch_q     <= 1'b0;
			bypass_q <= 1'b0;
			need_r_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_IDLE && sts.in_valid) begin
				bypass_q <= !sts.echo_en;
				ch_q     <= 1'b0;
			end
			if (state_q == ST_SAT) begin
				ch_q <= !ch_q;
			end
			if (state_q == ST_WRITE) begin
				need_r_q <= sts.need_r;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sts.in_valid) begin
					state_nxt = sts.echo_en ? ST_LVL : ST_WRITE;
				end
			end
			ST_LVL:  state_nxt = ST_SUM;
			ST_SUM:  state_nxt = ST_GAIN;
			ST_GAIN: state_nxt = ST_SAT;
			ST_SAT:  state_nxt = ch_q ? ST_WRITE : ST_LVL;
			ST_WRITE: begin
				if (sts.out_free) begin
					priority if (bypass_q) begin
						state_nxt = ST_IDLE;
					end else if (sts.need_w) begin
						state_nxt = ST_WMOD;
					end else if (sts.need_r) begin
						state_nxt = ST_RMOD;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_WMOD: begin
				if (sts.mod_done) begin
					state_nxt = need_r_q ? ST_RMOD : ST_IDLE;
				end
			end
			ST_RMOD: begin
				if (sts.mod_done) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl           = '0;
		ctl.ch        = ch_q;
		ctl.bypass    = bypass_q;
		ctl.in_ready  = (state_q == ST_IDLE);
		ctl.accept    = (state_q == ST_IDLE) && sts.in_valid;
		ctl.mul_lvl   = (state_q == ST_LVL);
		ctl.sum       = (state_q == ST_SUM);
		ctl.mul_gain  = (state_q == ST_GAIN);
		ctl.sat       = (state_q == ST_SAT);
		ctl.commit    = (state_q == ST_WRITE) && sts.out_free;
		ctl.wdone     = (state_q == ST_WMOD) && sts.mod_done;
		ctl.rdone     = (state_q == ST_RMOD) && sts.mod_done;
		if (ctl.commit && !bypass_q && sts.need_w) begin
			ctl.mod_start = 1'b1;
			ctl.mod_sel_r = 1'b0;
		end else if (ctl.commit && !bypass_q && sts.need_r) begin
			ctl.mod_start = 1'b1;
			ctl.mod_sel_r = 1'b1;
		end else if (ctl.wdone && need_r_q) begin
			ctl.mod_start = 1'b1;
			ctl.mod_sel_r = 1'b1;
		end
	end
endmodule
`default_nettype wire

[sv/stereo_feedback_echo_top.sv]
`default_nettype none
// Channel   Handshake                 Payload
// cfg       cfg_we                    cfg_index, cfg_data
// in        in_valid / in_ready       left_sample, right_sample, block_end
// out       out_valid / out_ready     left_out, right_out, block_end_out
//
// With echo on, an item holds the block from acceptance until its result enters the
// output register: one shared multiplier runs level and gain products for each
// channel in turn, with a sum and a truncate/saturate step between.
// When a shortened delay leaves a pointer past the new length, each such pointer
// also holds the block while the bit-serial remainder unit wraps it. With echo off an
// item goes from acceptance straight to the write step, where its result is registered.
// Reset leaves the ring reading as zero at once through a fill count; no clearing pass.
// A stalled output holds the block in its write step; a new item is taken once idle.
module stereo_feedback_echo_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire sfe_pkg::cfg_idx_t             cfg_index,
	input  wire logic [sfe_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [sfe_pkg::SAMPLE_W-1:0] left_sample,
	input  wire logic signed [sfe_pkg::SAMPLE_W-1:0] right_sample,
	input  wire logic                          block_end,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [sfe_pkg::SAMPLE_W-1:0] left_out,
	output logic signed [sfe_pkg::SAMPLE_W-1:0] right_out,
	output logic                               block_end_out
);
	import sfe_pkg::*;

	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam int Q_W = PROD_W - FRAC_SH;

	logic [15:0]      level_q;
	logic [CFG_W-1:0] gain_q;
	logic [CFG_W-1:0] delay_q;
	logic             enable_q;

	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] wp1;
	logic [LEN_W-1:0] rp1;

	logic signed [SAMPLE_W-1:0] x_l_q;
	logic signed [SAMPLE_W-1:0] x_r_q;
	logic                       be_q;
	logic signed [SAMPLE_W-1:0] res_l_q;
	logic signed [SAMPLE_W-1:0] res_r_q;
	logic signed [ACC_W-1:0]    acc_q;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] left_out_q;
	logic signed [SAMPLE_W-1:0] right_out_q;
	logic                       be_out_q;

	sts_t sts;
	ctl_t ctl;

	logic [2*SAMPLE_W-1:0]      ring_rd;
	logic signed [SAMPLE_W-1:0] d_ch;
	logic signed [SAMPLE_W-1:0] x_ch;
	logic signed [ACC_W-1:0]    mul_a;
	logic signed [COEF_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   biased;
	logic signed [Q_W-1:0]      q;
	logic signed [SAMPLE_W-1:0] sat_val;
	logic                       mod_done;
	logic [PTR_W-1:0]           mod_rem;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= 16'd32768;
			gain_q   <= CFG_W'(32768);
			delay_q  <= CFG_W'(10);
			enable_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ECHO_LEVEL:   level_q  <= cfg_data[15:0];
				CFG_NORM_GAIN:    gain_q   <= cfg_data;
				CFG_DELAY_LENGTH: delay_q  <= cfg_data;
				CFG_ECHO_ENABLE:  enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective ring length and pointer increments.
	always_comb begin
		if (delay_q < CFG_W'(2)) begin
			len = LEN_W'(2);
		end else if (delay_q > CFG_W'(MAX_DELAY)) begin
			len = LEN_W'(MAX_DELAY);
		end else begin
			len = LEN_W'(delay_q);
		end
	end

	assign wp1 = {1'b0, wp_q} + 1'b1;
	assign rp1 = {1'b0, rp_q} + 1'b1;

	assign sts.in_valid = in_valid;
	assign sts.echo_en  = enable_q;
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.need_w   = (wp1 > len);
	assign sts.need_r   = (rp1 > len);
	assign sts.mod_done = mod_done;

	sfe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	sfe_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (ctl.accept && enable_q),
		.rd_addr (rp_q),
		.we      (ctl.commit && !ctl.bypass),
		.wr_addr (wp_q),
		.wr_data ({res_r_q, res_l_q}),
		.rd_data (ring_rd)
	);

	sfe_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.mod_start),
		.dividend (ctl.mod_sel_r ? rp1 : wp1),
		.divisor  (len),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// Operand selection for the shared multiplier.
	assign d_ch = ctl.ch ? ring_rd[2*SAMPLE_W-1:SAMPLE_W] : ring_rd[SAMPLE_W-1:0];
	assign x_ch = ctl.ch ? x_r_q : x_l_q;

	always_comb begin
		if (ctl.mul_gain) begin
			mul_a = acc_q;
			mul_b = COEF_W'(gain_q);
		end else begin
			mul_a = ACC_W'(d_ch);
			mul_b = COEF_W'(level_q);
		end
	end

	sfe_mul u_mul (
		.clk  (clk),
		.en   (ctl.mul_lvl || ctl.mul_gain),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Truncate toward zero: negative products get a bias of one less than
	// the divisor before the arithmetic shift.
	always_comb begin
		biased = prod + (prod[PROD_W-1] ? PROD_W'((64'd1 << FRAC_SH) - 64'd1) : '0);
		q      = biased[PROD_W-1:FRAC_SH];
		if (q > Q_W'(SAT_MAX)) begin
			sat_val = SAT_MAX;
		end else if (q < Q_W'(SAT_MIN)) begin
			sat_val = SAT_MIN;
		end else begin
			sat_val = q[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			x_l_q <= left_sample;
			x_r_q <= right_sample;
			be_q  <= block_end;
		end
		if (ctl.sum) begin
			acc_q <= (ACC_W'(x_ch) <<< 15) + prod[ACC_W-1:0];
		end
		if (ctl.sat) begin
			if (ctl.ch) begin
				res_r_q <= sat_val;
			end else begin
				res_l_q <= sat_val;
			end
		end
		if (ctl.commit) begin
			left_out_q  <= ctl.bypass ? x_l_q : res_l_q;
			right_out_q <= ctl.bypass ? x_r_q : res_r_q;
			be_out_q    <= be_q;
		end
	end

	// Pointers advance at commit, or after the remainder unit when a pointer
	// has run past a shortened length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= PTR_W'(1);
		end else begin
			if (ctl.commit && !ctl.bypass) begin
				if (!sts.need_w) begin
					wp_q <= (wp1 == len) ? '0 : wp1[PTR_W-1:0];
				end
				if (!sts.need_r) begin
					rp_q <= (rp1 == len) ? '0 : rp1[PTR_W-1:0];
				end
			end
			if (ctl.wdone) begin
				wp_q <= mod_rem;
			end
			if (ctl.rdone) begin
				rp_q <= mod_rem;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready      = ctl.in_ready;
	assign out_valid     = out_valid_q;
	assign left_out      = left_out_q;
	assign right_out     = right_out_q;
	assign block_end_out = be_out_q;
endmodule
`default_nettype wire
